[src/rvde_pkg.sv]
// Shared types, opcodes and constants for the RV32 decode and execute unit.
package rvde_pkg;

    localparam int XLEN      = 32;
    localparam int REM_STEPS = XLEN;          // one quotient bit per remainder stage
    localparam int LATENCY   = REM_STEPS + 3; // decode, prep/alu, steps, output

    localparam logic [6:0] OPC_REG    = 7'b0110011;
    localparam logic [6:0] OPC_IMM    = 7'b0010011;
    localparam logic [6:0] OPC_LOAD   = 7'b0000011;
    localparam logic [6:0] OPC_STORE  = 7'b0100011;
    localparam logic [6:0] OPC_BRANCH = 7'b1100011;
    localparam logic [6:0] OPC_JAL    = 7'b1101111;
    localparam logic [6:0] OPC_JALR   = 7'b1100111;

    localparam logic [2:0] F3_ADD = 3'b000;
    localparam logic [2:0] F3_SLL = 3'b001;
    localparam logic [2:0] F3_LT  = 3'b100;
    localparam logic [2:0] F3_GE  = 3'b101;
    localparam logic [2:0] F3_OR  = 3'b110;
    localparam logic [2:0] F3_AND = 3'b111;

    localparam logic [XLEN-1:0] SHIFT_MAX = 32'd30;

    typedef enum logic [3:0] {
        SEL_AND, SEL_OR, SEL_ADD, SEL_LT, SEL_MUL, SEL_REM, SEL_SUB, SEL_GE, SEL_SLL
    } t_alu_sel;

    typedef enum logic [1:0] {
        WB_ALU  = 2'd0,
        WB_LOAD = 2'd1,
        WB_LINK = 2'd2
    } t_wb_src;

    typedef struct packed {
        logic    reg_write;
        logic    mem_read;
        logic    mem_write;
        t_wb_src wb_src;
        logic    branch;
        logic    jump;
    } t_ctrl;

    typedef struct packed {
        t_alu_sel        sel;
        logic [XLEN-1:0] src1;
        logic [XLEN-1:0] opb;
        logic [XLEN-1:0] src2;
        logic [XLEN-1:0] branch_target;
        logic [XLEN-1:0] jump_target;
        logic [XLEN-1:0] link;
        logic [4:0]      rd;
        t_ctrl           ctrl;
    } t_dec;

    typedef struct packed {
        logic            is_rem;
        logic [XLEN-1:0] result;
        logic [XLEN-1:0] src2;
        logic [XLEN-1:0] branch_target;
        logic [XLEN-1:0] jump_target;
        logic [XLEN-1:0] link;
        logic [4:0]      rd;
        t_ctrl           ctrl;
    } t_ex;

endpackage

[src/rvde_decode.sv]
// Decode stage: control flags, immediate, ALU select and address targets.
module rvde_decode (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [rvde_pkg::XLEN-1:0] i_instr,
    input  logic [rvde_pkg::XLEN-1:0] i_src1,
    input  logic [rvde_pkg::XLEN-1:0] i_src2,
    input  logic [rvde_pkg::XLEN-1:0] i_pc,
    output logic                       o_valid,
    output rvde_pkg::t_dec             o_dec
);

    logic [6:0]                 opc;
    logic [2:0]                 f3;
    logic [rvde_pkg::XLEN-1:0] imm_i, imm_s, imm_b, imm_j, imm;
    rvde_pkg::t_dec             n_dec;
    rvde_pkg::t_dec             r_dec;
    logic                       r_valid;

    assign opc   = i_instr[6:0];
    assign f3    = i_instr[14:12];
    assign imm_i = {{20{i_instr[31]}}, i_instr[31:20]};
    assign imm_s = {{20{i_instr[31]}}, i_instr[31:25], i_instr[11:7]};
    assign imm_b = {{20{i_instr[31]}}, i_instr[31], i_instr[7], i_instr[30:25],
                    i_instr[11:8]};
    assign imm_j = {{12{i_instr[31]}}, i_instr[31], i_instr[19:12], i_instr[20],
                    i_instr[30:21]};

    always_comb begin
        imm          = '0;
        n_dec.sel    = rvde_pkg::SEL_AND;
        n_dec.src1   = i_src1;
        n_dec.opb    = i_src2;
        n_dec.src2   = i_src2;
        n_dec.rd     = i_instr[11:7];
        n_dec.ctrl   = '{reg_write: 1'b0, mem_read: 1'b0, mem_write: 1'b0,
                         wb_src: rvde_pkg::WB_ALU, branch: 1'b0, jump: 1'b0};
        n_dec.jump_target = '0;
        unique case (opc)
            rvde_pkg::OPC_REG: begin
                n_dec.ctrl.reg_write = 1'b1;
                if (i_instr[30]) begin
                    if (f3 == rvde_pkg::F3_ADD) n_dec.sel = rvde_pkg::SEL_SUB;
                end else if (i_instr[25]) begin
                    if (f3 == rvde_pkg::F3_ADD) n_dec.sel = rvde_pkg::SEL_MUL;
                    else if (f3 == rvde_pkg::F3_OR) n_dec.sel = rvde_pkg::SEL_REM;
                end else begin
                    if (f3 == rvde_pkg::F3_ADD) n_dec.sel = rvde_pkg::SEL_ADD;
                    else if (f3 == rvde_pkg::F3_SLL) n_dec.sel = rvde_pkg::SEL_SLL;
                    else if (f3 == rvde_pkg::F3_OR) n_dec.sel = rvde_pkg::SEL_OR;
                end
            end
            rvde_pkg::OPC_IMM: begin
                n_dec.ctrl.reg_write = 1'b1;
                imm       = imm_i;
                n_dec.opb = imm_i;
                if (f3 == rvde_pkg::F3_ADD) n_dec.sel = rvde_pkg::SEL_ADD;
                else if (f3 == rvde_pkg::F3_SLL) n_dec.sel = rvde_pkg::SEL_SLL;
                else if (f3 == rvde_pkg::F3_OR) n_dec.sel = rvde_pkg::SEL_OR;
            end
            rvde_pkg::OPC_LOAD: begin
                n_dec.ctrl.reg_write = 1'b1;
                n_dec.ctrl.mem_read  = 1'b1;
                n_dec.ctrl.wb_src    = rvde_pkg::WB_LOAD;
                imm       = imm_i;
                n_dec.opb = imm_i;
                n_dec.sel = rvde_pkg::SEL_ADD;
            end
            rvde_pkg::OPC_STORE: begin
                n_dec.ctrl.mem_write = 1'b1;
                imm       = imm_s;
                n_dec.opb = imm_s;
                n_dec.sel = rvde_pkg::SEL_ADD;
            end
            rvde_pkg::OPC_BRANCH: begin
                n_dec.ctrl.branch = 1'b1;
                imm = imm_b;
                if (f3 == rvde_pkg::F3_ADD) n_dec.sel = rvde_pkg::SEL_SUB;
                else if (f3 == rvde_pkg::F3_LT) n_dec.sel = rvde_pkg::SEL_LT;
                else if (f3 == rvde_pkg::F3_GE) n_dec.sel = rvde_pkg::SEL_GE;
            end
            rvde_pkg::OPC_JAL: begin
                n_dec.ctrl.reg_write = 1'b1;
                n_dec.ctrl.jump      = 1'b1;
                n_dec.ctrl.wb_src    = rvde_pkg::WB_LINK;
                imm               = imm_j;
                n_dec.jump_target = i_pc + imm_j;
            end
            rvde_pkg::OPC_JALR: begin
                n_dec.ctrl.reg_write = 1'b1;
                n_dec.ctrl.jump      = 1'b1;
                n_dec.ctrl.wb_src    = rvde_pkg::WB_LINK;
                imm               = imm_i;
                n_dec.jump_target = i_src1 + imm_i;
            end
            default: begin
                imm = '0;
            end
        endcase
        n_dec.branch_target = i_pc + imm;
        n_dec.link          = i_pc + 32'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_dec <= n_dec;
    end

    assign o_valid = r_valid;
    assign o_dec   = r_dec;

endmodule

[src/rvde_alu.sv]
// Registered ALU stage: logic, add/sub, compare, shift and multiply.
module rvde_alu (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  rvde_pkg::t_dec i_dec,
    output logic           o_valid,
    output rvde_pkg::t_ex  o_ex
);

    logic [rvde_pkg::XLEN-1:0] a, b, res;
    logic                       lt;
    rvde_pkg::t_ex              n_ex;
    rvde_pkg::t_ex              r_ex;
    logic                       r_valid;

    assign a  = i_dec.src1;
    assign b  = i_dec.opb;
    assign lt = $signed(a) < $signed(b);

    always_comb begin
        unique case (i_dec.sel)
            rvde_pkg::SEL_OR:  res = a | b;
            rvde_pkg::SEL_ADD: res = a + b;
            rvde_pkg::SEL_LT:  res = {31'd0, ~lt};
            rvde_pkg::SEL_MUL: res = a * b;
            rvde_pkg::SEL_SUB: res = a - b;
            rvde_pkg::SEL_GE:  res = {31'd0, lt};
            rvde_pkg::SEL_SLL: res = (b <= rvde_pkg::SHIFT_MAX) ? (a << b[4:0]) : '0;
            default:           res = a & b;   // and; remainder is replaced later
        endcase
        n_ex.is_rem        = (i_dec.sel == rvde_pkg::SEL_REM);
        n_ex.result        = res;
        n_ex.src2          = i_dec.src2;
        n_ex.branch_target = i_dec.branch_target;
        n_ex.jump_target   = i_dec.jump_target;
        n_ex.link          = i_dec.link;
        n_ex.rd            = i_dec.rd;
        n_ex.ctrl          = i_dec.ctrl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_ex <= n_ex;
    end

    assign o_valid = r_valid;
    assign o_ex    = r_ex;

endmodule

[src/rvde_rem_pipe.sv]
// Pipelined signed remainder: magnitude prep stage, then one restoring step per stage.
module rvde_rem_pipe (
    input  logic                       i_clk,
    input  logic [rvde_pkg::XLEN-1:0] i_dividend,
    input  logic [rvde_pkg::XLEN-1:0] i_divisor,
    output logic [rvde_pkg::XLEN-1:0] o_rem_mag,
    output logic                       o_neg,
    output logic                       o_zero,
    output logic [rvde_pkg::XLEN-1:0] o_dividend
);

    localparam int N = rvde_pkg::REM_STEPS;
    localparam int W = rvde_pkg::XLEN;

    logic [W-1:0] r_rem [0:N];
    logic [W-1:0] r_dvd [0:N];
    logic [W-1:0] r_dvs [0:N];
    logic [W-1:0] r_raw [0:N];
    logic         r_neg [0:N];
    logic         r_zero[0:N];

    // prep: magnitudes and the special-case flags
    always_ff @(posedge i_clk) begin
        r_rem[0]  <= '0;
        r_dvd[0]  <= i_dividend[W-1] ? (W'(0) - i_dividend) : i_dividend;
        r_dvs[0]  <= i_divisor[W-1] ? (W'(0) - i_divisor) : i_divisor;
        r_raw[0]  <= i_dividend;
        r_neg[0]  <= i_dividend[W-1];
        r_zero[0] <= (i_divisor == '0);
    end

    for (genvar i = 0; i < N; i++) begin : g_step
        logic [W:0] trial, diff;
        assign trial = {r_rem[i], r_dvd[i][W-1]};
        assign diff  = trial - {1'b0, r_dvs[i]};

        always_ff @(posedge i_clk) begin
            r_rem[i+1]  <= diff[W] ? trial[W-1:0] : diff[W-1:0];
            r_dvd[i+1]  <= {r_dvd[i][W-2:0], 1'b0};
            r_dvs[i+1]  <= r_dvs[i];
            r_raw[i+1]  <= r_raw[i];
            r_neg[i+1]  <= r_neg[i];
            r_zero[i+1] <= r_zero[i];
        end
    end

    assign o_rem_mag  = r_rem[N];
    assign o_neg      = r_neg[N];
    assign o_zero     = r_zero[N];
    assign o_dividend = r_raw[N];

endmodule

[src/rv32_decode_execute_unit.sv]
// Top level of the RV32 decode and execute unit: stage chain and result register.
//
//  channel  | handshake          | payload
//  ---------+--------------------+----------------------------------------------------
//  command  | start / busy       | i_instr_word, i_src1_value, i_src2_value, i_pc_index
//  result   | o_valid (strobe)   | o_alu_result ... o_store_data, one beat per command
//
// Flow: one beat accepted per clock whenever out of reset. The accepting edge loads decode,
// then operand prep and the ALU, the remainder pipeline (one quotient bit per stage) and
// the output register follow in turn; the strobe rises as the output register loads.
// Reset: synchronous, active low; clears the valid bits only, busy is high in reset.
// Stalls: none; the pipe never holds. The receiver must take every strobe; the unit cannot check it.
module rv32_decode_execute_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic        [31:0] i_instr_word,
    input  logic signed [31:0] i_src1_value,
    input  logic signed [31:0] i_src2_value,
    input  logic        [31:0] i_pc_index,
    output logic               o_valid,
    output logic signed [31:0] o_alu_result,
    output logic        [31:0] o_branch_target,
    output logic        [31:0] o_jump_target,
    output logic        [31:0] o_link_value,
    output logic        [4:0]  o_dest_reg,
    output logic               o_reg_write,
    output logic               o_mem_read,
    output logic               o_mem_write,
    output logic        [1:0]  o_writeback_source,
    output logic               o_take_branch,
    output logic               o_is_jump,
    output logic signed [31:0] o_store_data
);

    localparam int N = rvde_pkg::REM_STEPS;
    localparam int W = rvde_pkg::XLEN;

    logic           dec_valid, ex_valid;
    rvde_pkg::t_dec dec;
    rvde_pkg::t_ex  ex;

    logic [W-1:0] rem_mag, rem_raw, rem_val, n_result;
    logic         rem_neg, rem_zero;

    // delay line that keeps the ALU beat aligned with the remainder pipe
    rvde_pkg::t_ex r_dly   [0:N-1];
    logic          r_dly_v [0:N-1];
    rvde_pkg::t_ex tail;

    logic         r_valid;
    logic [W-1:0] r_result;
    rvde_pkg::t_ex r_out;
    logic         r_take;

    // accept whenever out of reset; nothing downstream can push back
    assign busy = ~i_rst_n;

    rvde_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start & ~busy),
        .i_instr (i_instr_word),
        .i_src1  ($unsigned(i_src1_value)),
        .i_src2  ($unsigned(i_src2_value)),
        .i_pc    (i_pc_index),
        .o_valid (dec_valid),
        .o_dec   (dec)
    );

    rvde_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dec_valid),
        .i_dec   (dec),
        .o_valid (ex_valid),
        .o_ex    (ex)
    );

    rvde_rem_pipe u_rem (
        .i_clk      (i_clk),
        .i_dividend (dec.src1),
        .i_divisor  (dec.opb),
        .o_rem_mag  (rem_mag),
        .o_neg      (rem_neg),
        .o_zero     (rem_zero),
        .o_dividend (rem_raw)
    );

    // advance the ALU beat and its valid bit one stage per clock
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < N; k++) begin
                r_dly_v[k] <= 1'b0;
            end
        end else begin
            r_dly_v[0] <= ex_valid;
            for (int k = 1; k < N; k++) begin
                r_dly_v[k] <= r_dly_v[k-1];
            end
        end
        r_dly[0] <= ex;
        for (int k = 1; k < N; k++) begin
            r_dly[k] <= r_dly[k-1];
        end
    end

    assign tail = r_dly[N-1];

    // divide by zero hands back the dividend; otherwise the remainder takes
    // the dividend's sign
    assign rem_val  = rem_zero ? rem_raw : (rem_neg ? (W'(0) - rem_mag) : rem_mag);
    assign n_result = tail.is_rem ? rem_val : tail.result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_dly_v[N-1];
        end
        r_result <= n_result;
        r_out    <= tail;
        r_take   <= tail.ctrl.branch & (n_result == '0);
    end

    assign o_valid            = r_valid;
    assign o_alu_result       = $signed(r_result);
    assign o_branch_target    = r_out.branch_target;
    assign o_jump_target      = r_out.jump_target;
    assign o_link_value       = r_out.link;
    assign o_dest_reg         = r_out.rd;
    assign o_reg_write        = r_out.ctrl.reg_write;
    assign o_mem_read         = r_out.ctrl.mem_read;
    assign o_mem_write        = r_out.ctrl.mem_write;
    assign o_writeback_source = r_out.ctrl.wb_src;
    assign o_take_branch      = r_take;
    assign o_is_jump          = r_out.ctrl.jump;
    assign o_store_data       = $signed(r_out.src2);

`ifndef NO_ASSERTIONS
    // every accepted command yields its strobe
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##(rvde_pkg::LATENCY) o_valid)
        else $error("result strobe missing after accepted command");

    // a strobe always traces back to an accepted command
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, rvde_pkg::LATENCY))
        else $error("result strobe without command");

    // jumps write back the link value
    a_jump_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_jump) |-> (o_reg_write && o_writeback_source == rvde_pkg::WB_LINK))
        else $error("jump without link writeback");

    // a store never writes a register nor reads memory
    a_store_ctrl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_mem_write) |-> (!o_reg_write && !o_mem_read))
        else $error("store with register write or load");
`endif

endmodule

[tb/testbench.sv]
// Self-checking testbench for the RV32 decode and execute unit.
`timescale 1ns / 1ps

module testbench;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic        [31:0] i_instr_word;
    logic signed [31:0] i_src1_value;
    logic signed [31:0] i_src2_value;
    logic        [31:0] i_pc_index;
    logic               o_valid;
    logic signed [31:0] o_alu_result;
    logic        [31:0] o_branch_target;
    logic        [31:0] o_jump_target;
    logic        [31:0] o_link_value;
    logic        [4:0]  o_dest_reg;
    logic               o_reg_write;
    logic               o_mem_read;
    logic               o_mem_write;
    logic        [1:0]  o_writeback_source;
    logic               o_take_branch;
    logic               o_is_jump;
    logic signed [31:0] o_store_data;

    // One result beat, flattened in port order.
    typedef struct packed {
        logic [31:0] alu;
        logic [31:0] btgt;
        logic [31:0] jtgt;
        logic [31:0] link;
        logic [4:0]  rd;
        logic        rw;
        logic        mr;
        logic        mw;
        logic [1:0]  wb;
        logic        take;
        logic        jump;
        logic [31:0] sdata;
    } t_exec_out;

    typedef struct packed {
        logic [31:0] instr;
        logic [31:0] s1;
        logic [31:0] s2;
        logic [31:0] pc;
    } t_instr_beat;

    rv32_decode_execute_unit dut (.*);

    t_exec_out pending_results[$];
    int        mismatch_count;
    bit        stim_done;
    int        send_idle_pct;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #5ms;
        $display("testbench: FAIL");
        $finish;
    end

    function automatic logic [31:0] sext12(logic [11:0] v);
        return {{20{v[11]}}, v};
    endfunction

    // Truncated signed remainder; dividend returned on a zero divisor.
    function automatic logic [31:0] signed_rem(logic [31:0] a, logic [31:0] b);
        logic [31:0] ma, mb, r;
        if (b == 32'd0) return a;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        r  = ma % mb;
        return a[31] ? -r : r;
    endfunction

    function automatic t_exec_out exec_predict(t_instr_beat b);
        t_exec_out          e;
        logic [6:0]         opc;
        logic [2:0]         f3;
        logic [31:0]        imm, opb, res;
        rvde_pkg::t_alu_sel sel;
        opc = b.instr[6:0];
        f3  = b.instr[14:12];
        imm = '0;
        opb = b.s2;
        sel = rvde_pkg::SEL_AND;
        e   = '0;
        case (opc)
            rvde_pkg::OPC_REG: begin
                e.rw = 1'b1;
                if (b.instr[30]) begin
                    if (f3 == rvde_pkg::F3_ADD) sel = rvde_pkg::SEL_SUB;
                end else if (b.instr[25]) begin
                    if (f3 == rvde_pkg::F3_ADD) sel = rvde_pkg::SEL_MUL;
                    else if (f3 == rvde_pkg::F3_OR) sel = rvde_pkg::SEL_REM;
                end else begin
                    if (f3 == rvde_pkg::F3_ADD) sel = rvde_pkg::SEL_ADD;
                    else if (f3 == rvde_pkg::F3_SLL) sel = rvde_pkg::SEL_SLL;
                    else if (f3 == rvde_pkg::F3_OR) sel = rvde_pkg::SEL_OR;
                end
            end
            rvde_pkg::OPC_IMM: begin
                e.rw = 1'b1;
                imm  = sext12(b.instr[31:20]);
                opb  = imm;
                if (f3 == rvde_pkg::F3_ADD) sel = rvde_pkg::SEL_ADD;
                else if (f3 == rvde_pkg::F3_SLL) sel = rvde_pkg::SEL_SLL;
                else if (f3 == rvde_pkg::F3_OR) sel = rvde_pkg::SEL_OR;
            end
            rvde_pkg::OPC_LOAD: begin
                e.rw = 1'b1; e.mr = 1'b1; e.wb = rvde_pkg::WB_LOAD;
                imm  = sext12(b.instr[31:20]);
                opb  = imm;
                sel  = rvde_pkg::SEL_ADD;
            end
            rvde_pkg::OPC_STORE: begin
                e.mw = 1'b1;
                imm  = sext12({b.instr[31:25], b.instr[11:7]});
                opb  = imm;
                sel  = rvde_pkg::SEL_ADD;
            end
            rvde_pkg::OPC_BRANCH: begin
                imm = sext12({b.instr[31], b.instr[7], b.instr[30:25], b.instr[11:8]});
                if (f3 == rvde_pkg::F3_ADD) sel = rvde_pkg::SEL_SUB;
                else if (f3 == rvde_pkg::F3_LT) sel = rvde_pkg::SEL_LT;
                else if (f3 == rvde_pkg::F3_GE) sel = rvde_pkg::SEL_GE;
            end
            rvde_pkg::OPC_JAL: begin
                e.rw = 1'b1; e.jump = 1'b1; e.wb = rvde_pkg::WB_LINK;
                imm  = {{12{b.instr[31]}}, b.instr[31], b.instr[19:12], b.instr[20],
                        b.instr[30:21]};
                e.jtgt = b.pc + imm;
            end
            rvde_pkg::OPC_JALR: begin
                e.rw = 1'b1; e.jump = 1'b1; e.wb = rvde_pkg::WB_LINK;
                imm  = sext12(b.instr[31:20]);
                e.jtgt = b.s1 + imm;
            end
            default: ;
        endcase
        case (sel)
            rvde_pkg::SEL_OR:  res = b.s1 | opb;
            rvde_pkg::SEL_ADD: res = b.s1 + opb;
            rvde_pkg::SEL_LT:  res = ($signed(b.s1) < $signed(opb)) ? 32'd0 : 32'd1;
            rvde_pkg::SEL_GE:  res = ($signed(b.s1) < $signed(opb)) ? 32'd1 : 32'd0;
            rvde_pkg::SEL_MUL: res = b.s1 * opb;
            rvde_pkg::SEL_REM: res = signed_rem(b.s1, opb);
            rvde_pkg::SEL_SUB: res = b.s1 - opb;
            rvde_pkg::SEL_SLL: res = (opb <= 32'd30) ? (b.s1 << opb[4:0]) : 32'd0;
            default:           res = b.s1 & opb;
        endcase
        e.alu   = res;
        e.btgt  = b.pc + imm;
        e.link  = b.pc + 32'd1;
        e.rd    = b.instr[11:7];
        e.take  = (opc == rvde_pkg::OPC_BRANCH) && (res == 32'd0);
        e.sdata = b.s2;
        return e;
    endfunction

    // Hold the beat until accepted, idling beforehand at the current rate.
    task automatic issue_instr(t_instr_beat b);
        while ($urandom_range(99) < send_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start        <= 1'b1;
        i_instr_word <= b.instr;
        i_src1_value <= b.s1;
        i_src2_value <= b.s2;
        i_pc_index   <= b.pc;
        pending_results.insert(pending_results.size(), exec_predict(b));
        do @(posedge i_clk); while (busy);
    endtask

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return $urandom_range(40);
            4: return -$urandom_range(40);
            default: return $urandom;
        endcase
    endfunction

    // Mostly legal opcodes with random fields; some raw noise.
    function automatic t_instr_beat random_instr();
        t_instr_beat b;
        logic [6:0]  opcs[7] = '{rvde_pkg::OPC_REG, rvde_pkg::OPC_IMM, rvde_pkg::OPC_LOAD,
                                 rvde_pkg::OPC_STORE, rvde_pkg::OPC_BRANCH,
                                 rvde_pkg::OPC_JAL, rvde_pkg::OPC_JALR};
        b.instr = $urandom;
        if ($urandom_range(9) != 0) b.instr[6:0] = opcs[$urandom_range(6)];
        if (b.instr[6:0] == rvde_pkg::OPC_REG && $urandom_range(1)) begin
            b.instr[31:25] = $urandom_range(1) ? 7'b0100000 : 7'b0000001;
            if ($urandom_range(1)) b.instr[14:12] = rvde_pkg::F3_OR;
        end
        b.s1 = pick_operand();
        b.s2 = pick_operand();
        if ($urandom_range(3) == 0) b.s2 = b.s1;
        b.pc = $urandom_range(3) == 0 ? 32'hFFFF_FFFF : $urandom;
        return b;
    endfunction

    // Directed rows: one per operation and per special case.
    localparam int N_DIRECTED = 20;
    t_instr_beat directed[N_DIRECTED] = '{
        '{{7'b0000000, 5'd2, 5'd1, rvde_pkg::F3_ADD, 5'd31, rvde_pkg::OPC_REG},
          32'h7FFF_FFFF, 32'd1, 32'd0},
        '{{7'b0100000, 5'd2, 5'd1, rvde_pkg::F3_ADD, 5'd3, rvde_pkg::OPC_REG},
          32'h8000_0000, 32'd1, 32'd5},
        '{{7'b0000001, 5'd2, 5'd1, rvde_pkg::F3_ADD, 5'd4, rvde_pkg::OPC_REG},
          32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd9},
        '{{7'b0000001, 5'd2, 5'd1, rvde_pkg::F3_OR, 5'd5, rvde_pkg::OPC_REG},
          32'd17, 32'd0, 32'd1},
        '{{7'b0000001, 5'd2, 5'd1, rvde_pkg::F3_OR, 5'd6, rvde_pkg::OPC_REG},
          32'h8000_0000, 32'hFFFF_FFFF, 32'd1},
        '{{7'b0000001, 5'd2, 5'd1, rvde_pkg::F3_OR, 5'd7, rvde_pkg::OPC_REG},
          -32'sd7, 32'd3, 32'd1},
        '{{7'b0000000, 5'd2, 5'd1, rvde_pkg::F3_SLL, 5'd8, rvde_pkg::OPC_REG},
          32'd1, 32'd30, 32'd1},
        '{{7'b0000000, 5'd2, 5'd1, rvde_pkg::F3_SLL, 5'd8, rvde_pkg::OPC_REG},
          32'd1, 32'd31, 32'd1},
        '{{7'b0000000, 5'd2, 5'd1, rvde_pkg::F3_SLL, 5'd8, rvde_pkg::OPC_REG},
          32'd1, 32'hFFFF_FFFF, 32'd1},
        '{{12'hFFF, 5'd1, rvde_pkg::F3_AND, 5'd9, rvde_pkg::OPC_IMM},
          32'h1234_5678, 32'd0, 32'd2},
        '{{12'h800, 5'd1, rvde_pkg::F3_OR, 5'd9, rvde_pkg::OPC_IMM},
          32'd0, 32'd0, 32'd2},
        '{{12'h7FF, 5'd1, 3'b010, 5'd10, rvde_pkg::OPC_LOAD},
          32'd100, 32'd0, 32'd3},
        '{{7'h7F, 5'd2, 5'd1, 3'b010, 5'd31, rvde_pkg::OPC_STORE},
          32'd100, 32'hDEAD_BEEF, 32'd3},
        '{{7'h00, 5'd2, 5'd1, rvde_pkg::F3_ADD, 5'd8, rvde_pkg::OPC_BRANCH},
          32'd5, 32'd5, 32'd10},
        '{{7'h40, 5'd2, 5'd1, rvde_pkg::F3_LT, 5'd1, rvde_pkg::OPC_BRANCH},
          32'hFFFF_FFFF, 32'd0, 32'd10},
        '{{7'h3F, 5'd2, 5'd1, rvde_pkg::F3_GE, 5'd31, rvde_pkg::OPC_BRANCH},
          32'd0, 32'd0, 32'd10},
        '{{7'h00, 5'd2, 5'd1, rvde_pkg::F3_SLL, 5'd0, rvde_pkg::OPC_BRANCH},
          32'd6, 32'd1, 32'd10},
        '{32'hFFFF_F0EF, 32'd1, 32'd2, 32'hFFFF_FFFF},
        '{{12'h800, 5'd1, 3'b000, 5'd1, rvde_pkg::OPC_JALR},
          32'h8000_0000, 32'd2, 32'd40},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}
    };

    // Compare every strobed result with the oldest prediction.
    always @(posedge i_clk) begin
        t_exec_out got, want;
        if (i_rst_n && o_valid) begin
            got = {o_alu_result, o_branch_target, o_jump_target, o_link_value, o_dest_reg,
                   o_reg_write, o_mem_read, o_mem_write, o_writeback_source, o_take_branch,
                   o_is_jump, o_store_data};
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) $display("unexpected result beat: %p", got);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected %p actual %p", want, got);
                end
            end
        end
    end

    initial begin
        int wait_cycles;
        i_rst_n = 1'b0; start = 1'b0; i_instr_word = '0; i_src1_value = '0;
        i_src2_value = '0; i_pc_index = '0;
        mismatch_count = 0; send_idle_pct = 0; stim_done = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed[k]) issue_instr(directed[k]);
        // Sender idles at a rate of 35 percent, then 75 percent, then never.
        for (int n = 0; n < 1550; n++) begin
            send_idle_pct = (n < 520) ? 35 : (n < 1040) ? 75 : 0;
            issue_instr(random_instr());
        end
        start <= 1'b0;
        wait_cycles = 0;
        while (pending_results.size() != 0 && wait_cycles < 2000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (rvde_pkg::LATENCY + 10) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end
endmodule

[filelist.f]
src/rvde_pkg.sv
src/rvde_decode.sv
src/rvde_alu.sv
src/rvde_rem_pipe.sv
src/rv32_decode_execute_unit.sv
tb/testbench.sv
